[hw/rtl/preemptive_priority_scheduler_assert.svh]
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pps_pkg.sv]
package pps_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    // Fixed field widths.
    localparam int TIME_W = 16;
    localparam int URG_W  = 8;
    localparam int NOW_W  = 32;
    localparam int TC_W   = 5;

    // Configuration register indexes.
    localparam logic REG_TASK_COUNT = 1'b0;

    // Input word kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_TAT  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic upd;
        logic tat;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } stat_t;

    // Number of entries taking part: zero acts as one, large values clamp.
    function automatic logic [CNT_W-1:0] eff_count(input logic [TC_W-1:0] tc);
        logic [CNT_W-1:0] c;
        if (tc == '0)
        begin
            c = CNT_W'(1);
        end
        else if (32'(tc) > MAX_TASKS)
        begin
            c = CNT_W'(MAX_TASKS);
        end
        else
        begin
            c = CNT_W'(tc);
        end
        return c;
    endfunction

endpackage

[hw/rtl/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler. A load word (kind 0) writes one task entry. A tick word
// (kind 1) runs one time unit and returns one result word. A tick's time is set by the
// scan that reads one table entry per cycle through a single read port, followed by the
// update, turnaround and output states; the result is loaded in the output state and
// the next word can be taken in the cycle after. A new word is accepted only once the
// previous tick has loaded its result; the result register lets that word wait for the
// consumer while the next word is taken, and a tick whose result is ready while the
// previous one is still waiting stalls until the consumer takes it. task_count is
// written over the APB port at byte address 0; the user must write it only while the
// block is idle, which the block itself does not enforce; 0 acts as 1 and values
// above 16 act as 16.
module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [3:0]         slot,
    input  logic [TIME_W-1:0]  arrival_time,
    input  logic [TIME_W-1:0]  burst_time,
    input  logic [URG_W-1:0]   urgency,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               idle,
    output logic [3:0]         run_slot,
    output logic               finished,
    output logic [NOW_W-1:0]   finish_time,
    output logic [NOW_W-1:0]   turnaround,
    output logic [NOW_W-1:0]   waiting,
    output logic               all_done
);

`include "preemptive_priority_scheduler_assert.svh"

    logic [TC_W-1:0]  task_count_reg;
    logic [CNT_W-1:0] count;
    logic             reg_sel;
    cmd_t             cmd;
    stat_t            stat;
    logic [5:0]       cmd_bits;
    logic             tick_acc;
    logic             idle_clean;

    // Configuration register; the word offset picks the register.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_TASK_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= TC_W'(1);
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            task_count_reg <= pwdata[TC_W-1:0];
        end
    end

    assign prdata = reg_sel ? 32'(task_count_reg) : '0;
    assign count  = eff_count(task_count_reg);

    // Sequencer.
    pps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Task tables, scan and result datapath.
    pps_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .count        (count),
        .slot         (slot),
        .arrival_time (arrival_time),
        .burst_time   (burst_time),
        .urgency      (urgency),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .idle         (idle),
        .run_slot     (run_slot),
        .finished     (finished),
        .finish_time  (finish_time),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .all_done     (all_done)
    );

    // Terms the checks below look at.
    assign cmd_bits   = {cmd.load, cmd.start, cmd.scan, cmd.upd, cmd.tat, cmd.out_load};
    assign tick_acc   = in_valid && in_ready && (kind == KIND_TICK);
    assign idle_clean = !finished && (run_slot == 4'd0);

    // The sequencer issues at most one working command per cycle.
    `PPS_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd_bits), "more than one command at once")

    // A result is never loaded over a word the consumer has not taken.
    `PPS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result overwritten")

    // An accepted tick starts the scan in the next cycle.
    `PPS_ASSERT_NEXT(a_tick_scans, tick_acc, cmd.scan && !in_ready, "tick did not start a scan")

    // An idle tick names no task and finishes nothing.
    `PPS_ASSERT_NOW(a_idle_word, out_valid && idle, idle_clean, "idle result carries a task")

endmodule

[hw/rtl/pps_ctrl.sv]
module pps_ctrl
    import pps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  kind,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Words are taken only between ticks.
    assign in_ready = (state_reg == ST_IDLE);

    // Command decode.
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid && (kind == KIND_LOAD);
        cmd.start    = (state_reg == ST_IDLE) && in_valid && (kind == KIND_TICK);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.upd      = (state_reg == ST_UPD);
        cmd.tat      = (state_reg == ST_TAT);
        cmd.out_load = (state_reg == ST_OUT) && stat.out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_TAT;
            end
            ST_TAT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/pps_dp.sv]
module pps_dp
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [CNT_W-1:0]   count,
    input  logic [3:0]         slot,
    input  logic [TIME_W-1:0]  arrival_time,
    input  logic [TIME_W-1:0]  burst_time,
    input  logic [URG_W-1:0]   urgency,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               idle,
    output logic [3:0]         run_slot,
    output logic               finished,
    output logic [NOW_W-1:0]   finish_time,
    output logic [NOW_W-1:0]   turnaround,
    output logic [NOW_W-1:0]   waiting,
    output logic               all_done
);

    // Task tables; arrival, burst and urgency are meaningful once loaded.
    logic [TIME_W-1:0] arr_mem [MAX_TASKS];
    logic [TIME_W-1:0] bur_mem [MAX_TASKS];
    logic [URG_W-1:0]  urg_mem [MAX_TASKS];
    logic [TIME_W-1:0] rem_reg [MAX_TASKS];

    // Scheduler state.
    logic [SLOT_W-1:0] running_slot_reg;
    logic              running_valid_reg;
    logic [NOW_W-1:0]  now_reg;

    // Per-tick working registers.
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [URG_W-1:0]  best_urg_reg;
    logic              have_reg;
    logic [CNT_W-1:0]  zero_cnt_reg;
    logic              fin_flag_reg;
    logic [NOW_W-1:0]  fin_reg;
    logic [NOW_W-1:0]  tat_reg;
    logic [TIME_W-1:0] arr_reg;
    logic [TIME_W-1:0] bur_reg;

    // Output word registers.
    logic              out_valid_reg;
    logic              idle_reg;
    logic [3:0]        run_slot_reg;
    logic              finished_reg;
    logic [NOW_W-1:0]  finish_time_reg;
    logic [NOW_W-1:0]  turnaround_reg;
    logic [NOW_W-1:0]  waiting_reg;
    logic              all_done_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic [TIME_W-1:0] rem_rd;
    logic [TIME_W-1:0] arr_rd;
    logic [URG_W-1:0]  urg_rd;
    logic              elig;
    logic              run_ok;
    logic              better;
    logic              last_one;
    logic [SLOT_W-1:0] ld_addr;
    logic              ld_ok;
    logic [NOW_W-1:0]  wait_val;
    logic [CNT_W-1:0]  done_total;

    // One table read port: running task while idle, scan entry, then the winner.
    always_comb
    begin
        if (cmd.upd)
        begin
            rd_addr = best_reg;
        end
        else if (cmd.scan)
        begin
            rd_addr = idx_reg;
        end
        else
        begin
            rd_addr = running_slot_reg;
        end
    end

    assign rem_rd = rem_reg[rd_addr];
    assign arr_rd = arr_mem[rd_addr];
    assign urg_rd = urg_mem[rd_addr];

    // An entry is ready when it has work left and has arrived.
    assign elig   = (rem_rd != '0) && (NOW_W'(arr_rd) <= now_reg);
    assign run_ok = running_valid_reg && (CNT_W'(running_slot_reg) < count) && elig;
    assign better = elig && (!have_reg || (urg_rd < best_urg_reg));
    assign last_one = (rem_rd == TIME_W'(1));

    // Loads beyond the table are dropped.
    assign ld_addr = SLOT_W'(slot);
    assign ld_ok   = (32'(slot) < MAX_TASKS);

    assign stat.scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Waiting time is turnaround less burst, never below zero.
    assign wait_val = (tat_reg > NOW_W'(bur_reg)) ? (tat_reg - NOW_W'(bur_reg)) : '0;

    // Entries found empty during the scan, plus the one that just finished.
    assign done_total = zero_cnt_reg + CNT_W'(fin_flag_reg);

    // Payload tables have no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load && ld_ok)
        begin
            arr_mem[ld_addr] <= arrival_time;
            bur_mem[ld_addr] <= burst_time;
            urg_mem[ld_addr] <= urgency;
        end
    end

    // Remaining work: set by a load, counted down by the winning task.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.load && ld_ok)
        begin
            rem_reg[ld_addr] <= burst_time;
        end
        else if (cmd.upd && have_reg)
        begin
            rem_reg[best_reg] <= rem_rd - TIME_W'(1);
        end
    end

    // Running task and time counter, updated once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_slot_reg  <= '0;
            running_valid_reg <= 1'b0;
            now_reg           <= '0;
        end
        else if (cmd.upd)
        begin
            if (have_reg && !last_one)
            begin
                running_valid_reg <= 1'b1;
                running_slot_reg  <= best_reg;
            end
            else
            begin
                running_valid_reg <= 1'b0;
                running_slot_reg  <= '0;
            end
            if (now_reg != '1)
            begin
                now_reg <= now_reg + NOW_W'(1);
            end
        end
    end

    // Scan state: seeded by the running task, then one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            best_reg     <= '0;
            have_reg     <= 1'b0;
            zero_cnt_reg <= '0;
            fin_flag_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            idx_reg      <= '0;
            best_reg     <= running_slot_reg;
            have_reg     <= run_ok;
            zero_cnt_reg <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (better)
            begin
                best_reg <= idx_reg;
                have_reg <= 1'b1;
            end
            if (rem_rd == '0)
            begin
                zero_cnt_reg <= zero_cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.upd)
        begin
            fin_flag_reg <= have_reg && last_one;
        end
    end

    // Datapath payload for the scan and the completion times.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_urg_reg <= urg_rd;
        end
        else if (cmd.scan && better)
        begin
            best_urg_reg <= urg_rd;
        end
        if (cmd.upd)
        begin
            fin_reg <= (now_reg == '1) ? now_reg : (now_reg + NOW_W'(1));
            arr_reg <= arr_rd;
            bur_reg <= bur_mem[rd_addr];
        end
        if (cmd.tat)
        begin
            tat_reg <= fin_reg - NOW_W'(arr_reg);
        end
    end

    // Output word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload; times read zero unless the task finished.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            idle_reg        <= !have_reg;
            run_slot_reg    <= have_reg ? 4'(best_reg) : 4'd0;
            finished_reg    <= fin_flag_reg;
            finish_time_reg <= fin_flag_reg ? fin_reg : '0;
            turnaround_reg  <= fin_flag_reg ? tat_reg : '0;
            waiting_reg     <= fin_flag_reg ? wait_val : '0;
            all_done_reg    <= (done_total == count);
        end
    end

    assign out_valid   = out_valid_reg;
    assign idle        = idle_reg;
    assign run_slot    = run_slot_reg;
    assign finished    = finished_reg;
    assign finish_time = finish_time_reg;
    assign turnaround  = turnaround_reg;
    assign waiting     = waiting_reg;
    assign all_done    = all_done_reg;

endmodule

[tb/tb_preemptive_priority_scheduler.sv]
`timescale 1ns / 100ps

package tb_pps_sched_pkg;

    import pps_pkg::*;

    // One input word as the sender drives it.
    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [URG_W-1:0]  urgency;
    } sched_word_t;

    // One result word as the block returns it for a tick.
    typedef struct packed {
        logic              idle;
        logic [SLOT_W-1:0] run_slot;
        logic              finished;
        logic [NOW_W-1:0]  finish_time;
        logic [NOW_W-1:0]  turnaround;
        logic [NOW_W-1:0]  waiting;
        logic              all_done;
    } tick_result_t;

    // Keeps a private copy of the task table, predicts each tick and checks the block.
    class tick_scoreboard;

        bit [TIME_W-1:0] arrival_tbl [MAX_TASKS];
        bit [TIME_W-1:0] burst_tbl [MAX_TASKS];
        bit [URG_W-1:0]  urgency_tbl [MAX_TASKS];
        bit [TIME_W-1:0] remaining_tbl [MAX_TASKS];
        bit [SLOT_W-1:0] running_slot;
        bit              running_valid;
        bit [NOW_W-1:0]  now_tick;
        bit [TC_W-1:0]   task_count;

        tick_result_t expected_ticks [$];

        int mismatches;
        int results_seen;
        int tick_words;
        int load_words;
        int completions;
        int idle_ticks;

        function new();
            task_count = TC_W'(1);
        endfunction

        // Zero counts as one entry and anything past the table is clamped.
        function int active_entries();
            int c;
            c = int'(task_count);
            if (c == 0)
            begin
                c = 1;
            end
            if (c > MAX_TASKS)
            begin
                c = MAX_TASKS;
            end
            return c;
        endfunction

        function bit can_run(int i);
            return remaining_tbl[i] != '0 && NOW_W'(arrival_tbl[i]) <= now_tick;
        endfunction

        function void compare_field(string what, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (result %0d)",
                             what, want, got, results_seen);
                end
            end
        endfunction

        // An accepted word either rewrites one entry or runs one time unit.
        function void note_word(sched_word_t w);
            int cnt;
            int i;
            int best;
            bit have;
            int done_entries;
            bit [NOW_W-1:0] fin;
            tick_result_t r;

            if (w.kind == KIND_LOAD)
            begin
                load_words++;
                arrival_tbl[w.slot]   = w.arrival;
                burst_tbl[w.slot]     = w.burst;
                urgency_tbl[w.slot]   = w.urgency;
                remaining_tbl[w.slot] = w.burst;
                return;
            end

            tick_words++;
            cnt  = active_entries();
            have = 1'b0;
            best = 0;
            r    = '0;

            // The running task is the incumbent only while it is still in range and eligible.
            if (running_valid && int'(running_slot) < cnt && can_run(int'(running_slot)))
            begin
                best = int'(running_slot);
                have = 1'b1;
            end
            for (i = 0; i < cnt; i++)
            begin
                if (can_run(i) && (!have || urgency_tbl[i] < urgency_tbl[best]))
                begin
                    best = i;
                    have = 1'b1;
                end
            end

            if (have)
            begin
                remaining_tbl[best] = remaining_tbl[best] - 1'b1;
                r.run_slot = SLOT_W'(best);
                if (remaining_tbl[best] == '0)
                begin
                    fin = (now_tick == '1) ? now_tick : now_tick + 1'b1;
                    r.finished    = 1'b1;
                    r.finish_time = fin;
                    r.turnaround  = fin - NOW_W'(arrival_tbl[best]);
                    if (r.turnaround > NOW_W'(burst_tbl[best]))
                    begin
                        r.waiting = r.turnaround - NOW_W'(burst_tbl[best]);
                    end
                    running_valid = 1'b0;
                    running_slot  = '0;
                    completions++;
                end
                else
                begin
                    running_valid = 1'b1;
                    running_slot  = SLOT_W'(best);
                end
            end
            else
            begin
                r.idle        = 1'b1;
                running_valid = 1'b0;
                running_slot  = '0;
                idle_ticks++;
            end

            done_entries = 0;
            for (i = 0; i < cnt; i++)
            begin
                if (remaining_tbl[i] == '0)
                begin
                    done_entries++;
                end
            end
            r.all_done = (done_entries == cnt);

            if (now_tick != '1)
            begin
                now_tick = now_tick + 1'b1;
            end
            expected_ticks.push_back(r);
        endfunction

        // Every result word must match the oldest prediction still waiting.
        function void check_tick(tick_result_t got);
            tick_result_t want;
            results_seen++;
            if (expected_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("MISMATCH unexpected result word: idle %0d run_slot %0d finished %0d",
                             got.idle, got.run_slot, got.finished);
                end
                return;
            end
            want = expected_ticks.pop_front();
            compare_field("idle", want.idle, got.idle);
            compare_field("run_slot", want.run_slot, got.run_slot);
            compare_field("finished", want.finished, got.finished);
            compare_field("finish_time", want.finish_time, got.finish_time);
            compare_field("turnaround", want.turnaround, got.turnaround);
            compare_field("waiting", want.waiting, got.waiting);
            compare_field("all_done", want.all_done, got.all_done);
        endfunction

    endclass

endpackage

module tb_preemptive_priority_scheduler;

    import pps_pkg::*;
    import tb_pps_sched_pkg::*;

    localparam int UNMAPPED_REG = 1;
    localparam logic [2:0] ADDR_TASK_COUNT = 3'(4 * REG_TASK_COUNT);
    localparam logic [2:0] ADDR_UNMAPPED   = 3'(4 * UNMAPPED_REG);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 50;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 325;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic [3:0]         slot;
    logic [TIME_W-1:0]  arrival_time;
    logic [TIME_W-1:0]  burst_time;
    logic [URG_W-1:0]   urgency;
    logic               out_valid;
    logic               out_ready;
    logic               idle;
    logic [3:0]         run_slot;
    logic               finished;
    logic [NOW_W-1:0]   finish_time;
    logic [NOW_W-1:0]   turnaround;
    logic [NOW_W-1:0]   waiting;
    logic               all_done;

    tick_scoreboard sb;
    int send_gap_pct;
    int recv_stall_pct;
    int settings_used;
    int cycle_count;

    preemptive_priority_scheduler u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a run that outlives the limit has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("preemptive_priority_scheduler verification failed");
        $finish;
    end

    // Result side: sample at the edge, then pick the ready level for the next cycle.
    initial
    begin
        tick_result_t got;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.idle        = idle;
                got.run_slot    = run_slot;
                got.finished    = finished;
                got.finish_time = finish_time;
                got.turnaround  = turnaround;
                got.waiting     = waiting;
                got.all_done    = all_done;
                sb.check_tick(got);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write task_count, mirror it in the scoreboard and read it back.
    task automatic set_task_count(input logic [TC_W-1:0] value);
        logic [31:0] rd;
        apb_write(ADDR_TASK_COUNT, 32'(value));
        sb.task_count = value;
        settings_used++;
        apb_read(ADDR_TASK_COUNT, rd);
        sb.compare_field("task_count readback", 64'(value), 64'(rd));
    endtask

    // Present one word after a random gap and hold it until it is taken.
    task automatic send_word(input sched_word_t w);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= w.kind;
        slot         <= w.slot;
        arrival_time <= w.arrival;
        burst_time   <= w.burst;
        urgency      <= w.urgency;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_word(w);
    endtask

    // Stop sending, let every predicted word arrive, then let a load still in flight settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_ticks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sched_word_t load_word(input int s, input int arr, input int bur,
                                              input int urg);
        sched_word_t w;
        w.kind    = KIND_LOAD;
        w.slot    = SLOT_W'(s);
        w.arrival = TIME_W'(arr);
        w.burst   = TIME_W'(bur);
        w.urgency = URG_W'(urg);
        return w;
    endfunction

    function automatic sched_word_t tick_word();
        sched_word_t w;
        w      = sched_word_t'({$urandom, $urandom});
        w.kind = KIND_TICK;
        return w;
    endfunction

    // Mostly plausible loads near the current time, with reloads of the running task,
    // far arrivals, long and zero bursts mixed in.
    function automatic sched_word_t random_word();
        sched_word_t w;
        int cnt;
        int r;
        longint arr;
        if ($urandom_range(99) < 55)
        begin
            return tick_word();
        end
        w      = sched_word_t'({$urandom, $urandom});
        w.kind = KIND_LOAD;
        cnt    = sb.active_entries();

        r = $urandom_range(99);
        if (r < 10 && sb.running_valid)
        begin
            w.slot = sb.running_slot;
        end
        else if (r < 85)
        begin
            w.slot = SLOT_W'($urandom_range(cnt - 1, 0));
        end

        r = $urandom_range(99);
        if (r < 65)
        begin
            arr = longint'(sb.now_tick) + $urandom_range(6, 0);
        end
        else if (r < 75)
        begin
            arr = 0;
        end
        else if (r < 85)
        begin
            arr = $urandom_range(65535, 0);
        end
        else
        begin
            arr = longint'(sb.now_tick) - $urandom_range(20, 0);
        end
        if (arr < 0)
        begin
            arr = 0;
        end
        if (arr > 65535)
        begin
            arr = 65535;
        end
        w.arrival = TIME_W'(arr);

        r = $urandom_range(99);
        if (r < 73)
        begin
            w.burst = TIME_W'($urandom_range(6, 1));
        end
        else if (r < 85)
        begin
            w.burst = TIME_W'($urandom_range(40, 7));
        end
        else if (r < 93)
        begin
            w.burst = TIME_W'($urandom_range(65535, 1));
        end
        else if (r < 97)
        begin
            w.burst = '1;
        end
        else
        begin
            w.burst = '0;
        end

        r = $urandom_range(99);
        if (r < 80)
        begin
            w.urgency = URG_W'($urandom_range(15, 0));
        end
        else if (r < 95)
        begin
            w.urgency = URG_W'($urandom_range(255, 0));
        end
        else
        begin
            w.urgency = ($urandom_range(1, 0) == 1) ? '1 : '0;
        end
        return w;
    endfunction

    initial
    begin
        logic [31:0] rd;
        int s;
        int p;
        int n;
        logic [TC_W-1:0] phase_counts [PHASES];

        sb             = new();
        settings_used  = 0;
        send_gap_pct   = 6;
        recv_stall_pct = 55;
        phase_counts   = '{TC_W'(16), TC_W'(0), TC_W'(31), TC_W'(1), TC_W'(9), TC_W'(17)};

        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        kind         <= KIND_LOAD;
        slot         <= '0;
        arrival_time <= '0;
        burst_time   <= '0;
        urgency      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full table; a write past the register list must leave task_count alone.
        set_task_count(TC_W'(16));
        apb_write(ADDR_UNMAPPED, 32'h1f);
        apb_read(ADDR_TASK_COUNT, rd);
        sb.compare_field("task_count after unmapped write", 64'd16, 64'(rd));

        // Load every entry before any tick so no scan meets an unwritten entry.
        // Entry 1 never arrives, entry 2 preempts entry 0, entry 3 has no work at all.
        send_word(load_word(0, 2, 3, 30));
        send_word(load_word(1, 65535, 65535, 255));
        send_word(load_word(2, 3, 1, 0));
        send_word(load_word(3, 0, 0, 0));
        for (s = 4; s < MAX_TASKS; s++)
        begin
            send_word(load_word(s, 5 + s % 3, 1 + s % 2, 40 + 10 * (s % 4)));
        end

        // Two idle ticks, entry 0 starts, entry 2 preempts and finishes, entry 0 resumes.
        repeat (5) send_word(tick_word());

        // A reloaded running task that is still eligible keeps the slot.
        send_word(load_word(int'(sb.running_slot), int'(sb.now_tick), 2, 30));
        send_word(tick_word());

        // A reloaded running task that has not arrived yet is dropped.
        send_word(load_word(int'(sb.running_slot), int'(sb.now_tick) + 3, 2, 30));
        repeat (3) send_word(tick_word());

        // Random phases over several table sizes and handshake idling patterns.
        for (p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                send_gap_pct   = 6;
                recv_stall_pct = 55;
            end
            else if (p < 4)
            begin
                send_gap_pct   = 55;
                recv_stall_pct = 6;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            if (p > 0)
            begin
                drain_results();
                set_task_count(phase_counts[p]);
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                send_word(random_word());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d load words and %0d tick words over %0d task_count settings.",
                 sb.load_words, sb.tick_words, settings_used);
        $display("Checked %0d result words: %0d completions, %0d idle ticks, %0d mismatches.",
                 sb.results_seen, sb.completions, sb.idle_ticks, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_ticks.size() == 0)
        begin
            $display("preemptive_priority_scheduler verification clean");
        end
        else
        begin
            $display("preemptive_priority_scheduler verification failed");
        end
        $finish;
    end

endmodule
